[src/lss_pkg.sv]
// Package for the LIFO stack with search: action and status codes, sequencer states
// and fixed field widths. No dependencies.
package lss_pkg;

  localparam int unsigned ActionWidth = 2;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned PosWidth    = 5;
  localparam int unsigned StatusWidth = 3;

  typedef enum logic [ActionWidth-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

[src/lss_in_if.sv]
// Request channel of the LIFO stack with search: valid/ready plus action, value, position.
// Depends on lss_pkg.
interface lss_in_if;
  logic                                valid;
  logic                                ready;
  lss_pkg::action_e                    action;
  logic signed [lss_pkg::ValueWidth-1:0] value;
  logic [lss_pkg::PosWidth-1:0]        position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink (input valid, input action, input value, input position, output ready);
  modport monitor (input valid, input ready, input action, input value, input position);
endinterface

[src/lss_out_if.sv]
// Result channel of the LIFO stack with search: valid/ready plus status, data, position,
// count and empty flag. Depends on lss_pkg.
interface lss_out_if;
  logic                                  valid;
  logic                                  ready;
  lss_pkg::status_e                      status;
  logic signed [lss_pkg::ValueWidth-1:0] data;
  logic [lss_pkg::PosWidth-1:0]          found_position;
  logic [lss_pkg::PosWidth-1:0]          count;
  logic                                  empty_res;

  modport source (output valid, output status, output data, output found_position,
                  output count, output empty_res, input ready);
  modport sink (input valid, input status, input data, input found_position,
                input count, input empty_res, output ready);
  modport monitor (input valid, input ready, input status, input data, input found_position,
                   input count, input empty_res);
endinterface

[src/lss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/lifo_stack_with_search.sv]
// LIFO stack with search: top level with sequencer, fill count and result register.
// Depends on lss_pkg, lss_in_if, lss_out_if and lss_ram.
//
// A bounded last-in first-out store of DEPTH words of DATA_WIDTH bits, held in one RAM
// with a single read port. One request is taken at a time; the request channel is ready
// only while the sequencer is idle, and the finished result sits in an output register
// so a new request can be taken while it waits. After acceptance, each request passes
// through dispatch and finish; pop and find add one RAM read between them unless they
// fail. Search walks the stack from the top, one entry per cycle through the RAM read
// port, and stops at the first match or after the bottom entry when nothing matches.
// A full result register that is not drained stalls the sequencer before it returns
// to idle.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lss_in_if.sink   in_i,
  lss_out_if.source out_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned PW   = lss_pkg::PosWidth;
  localparam int unsigned VW   = lss_pkg::ValueWidth;
  localparam int unsigned CMPW = (CW > PW) ? CW : PW;

  lss_pkg::state_e  state_q, state_d;
  lss_pkg::action_e act_q, act_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [CW-1:0]         idx_q, idx_d;
  lss_pkg::status_e      res_status_q, res_status_d;
  logic [VW-1:0]         res_data_q, res_data_d;
  logic [PW-1:0]         res_fpos_q, res_fpos_d;

  logic                  out_valid_q, out_valid_d;
  lss_pkg::status_e      out_status_q, out_status_d;
  logic [VW-1:0]         out_data_q, out_data_d;
  logic [PW-1:0]         out_fpos_q, out_fpos_d;
  logic [PW-1:0]         out_count_q, out_count_d;
  logic                  out_empty_q, out_empty_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [VW-1:0]         data_ext;
  logic [CMPW-1:0]       find_off;
  logic [CW-1:0]         top_idx;
  logic [CW-1:0]         next_idx;
  logic                  slot_free;

  lss_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (word_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  if (DATA_WIDTH >= VW) begin : g_data_trunc
    assign data_ext = ram_rdata[VW-1:0];
  end else begin : g_data_sext
    assign data_ext = {{(VW - DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
  end

  assign find_off  = CMPW'(fill_q) - CMPW'(pos_q);
  assign top_idx   = fill_q - CW'(1);
  assign next_idx  = fill_q - idx_q - CW'(1);
  assign ram_waddr = fill_q[AW-1:0];
  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready = (state_q == lss_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    word_d       = word_q;
    pos_d        = pos_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_fpos_d   = res_fpos_q;
    ram_we       = 1'b0;
    ram_raddr    = top_idx[AW-1:0];

    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_fpos_d   = out_fpos_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;

    case (state_q)
      lss_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          word_d  = DATA_WIDTH'($unsigned(in_i.value));
          pos_d   = in_i.position;
          state_d = lss_pkg::ST_DISPATCH;
        end
      end
      lss_pkg::ST_DISPATCH: begin
        res_status_d = lss_pkg::STAT_OK;
        res_data_d   = '0;
        res_fpos_d   = '0;
        case (act_q)
          lss_pkg::ACT_PUSH: begin
            state_d = lss_pkg::ST_FINISH;
            if (fill_q == CW'(DEPTH)) begin
              res_status_d = lss_pkg::STAT_FULL;
            end else begin
              ram_we = 1'b1;
              fill_d = fill_q + CW'(1);
            end
          end
          lss_pkg::ACT_POP: begin
            if (fill_q == '0) begin
              res_status_d = lss_pkg::STAT_EMPTY;
              state_d      = lss_pkg::ST_FINISH;
            end else begin
              fill_d  = top_idx;
              state_d = lss_pkg::ST_READ;
            end
          end
          lss_pkg::ACT_FIND: begin
            ram_raddr = find_off[AW-1:0];
            if (pos_q == '0 || CMPW'(pos_q) > CMPW'(fill_q)) begin
              res_status_d = lss_pkg::STAT_BADPOS;
              state_d      = lss_pkg::ST_FINISH;
            end else begin
              state_d = lss_pkg::ST_READ;
            end
          end
          default: begin
            idx_d = CW'(1);
            if (fill_q == '0) begin
              res_status_d = lss_pkg::STAT_NOTFOUND;
              state_d      = lss_pkg::ST_FINISH;
            end else begin
              state_d = lss_pkg::ST_SCAN;
            end
          end
        endcase
      end
      lss_pkg::ST_READ: begin
        res_data_d = data_ext;
        state_d    = lss_pkg::ST_FINISH;
      end
      lss_pkg::ST_SCAN: begin
        ram_raddr = next_idx[AW-1:0];
        if (ram_rdata == word_q) begin
          res_fpos_d = PW'(idx_q);
          state_d    = lss_pkg::ST_FINISH;
        end else if (idx_q == fill_q) begin
          res_status_d = lss_pkg::STAT_NOTFOUND;
          state_d      = lss_pkg::ST_FINISH;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      lss_pkg::ST_FINISH: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_fpos_d   = res_fpos_q;
          out_count_d  = PW'(fill_q);
          out_empty_d  = (fill_q == '0);
          state_d      = lss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lss_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    word_q       <= word_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_fpos_q   <= res_fpos_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_fpos_q   <= out_fpos_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.data           = out_data_q;
  assign out_o.found_position = out_fpos_q;
  assign out_o.count          = out_count_q;
  assign out_o.empty_res      = out_empty_q;

endmodule

[src/lss_checker.sv]
// Port-level checks for the LIFO stack with search, bound to the top level.
// Depends on lss_pkg, lss_in_if and lss_out_if.
module lss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  lss_in_if.sink    in_i,
  lss_out_if.source out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data)
      && $stable(out_o.status))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("new transaction taken while one is in progress");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.empty_res == (out_o.count == '0)))
    else $error("empty flag disagrees with count");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != lss_pkg::STAT_OK
      |-> out_o.data == '0 && out_o.found_position == '0)
    else $error("error result carries data or position");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == lss_pkg::STAT_EMPTY |-> out_o.count == '0)
    else $error("empty status with nonzero count");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
